// File: rtl/rgbq_pkg.sv
// Shared types and constants for the RGB blend to NV12 quad block.
// No dependencies; every other file of the block but rgbq_ram imports this package.
package rgbq_pkg;

   localparam int VIS_MAX_W = 1024;
   localparam int VIS_MAX_H = 1024;
   localparam int OUT_MAX_W = 4096;
   localparam int OUT_MAX_H = 4096;

   localparam int STORE_AW    = 20;
   localparam int STORE_DEPTH = 1 << STORE_AW;
   localparam int PIX_W       = 24;
   localparam int QUOT_W      = 11;
   localparam int DIVIDEND_W  = 23;
   localparam int DIVISOR_W   = 13;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_FUSE = 1'b1;

   localparam logic [2:0] CSR_VIS_W  = 3'd0;
   localparam logic [2:0] CSR_VIS_H  = 3'd1;
   localparam logic [2:0] CSR_OUT_W  = 3'd2;
   localparam logic [2:0] CSR_OUT_H  = 3'd3;
   localparam logic [2:0] CSR_WEIGHT = 3'd4;
   localparam logic [2:0] CSR_OFF_X  = 3'd5;
   localparam logic [2:0] CSR_OFF_Y  = 3'd6;

   // Effective (already saturated) configuration seen by the front part.
   typedef struct packed {
      logic [10:0]        vis_w;
      logic [10:0]        vis_h;
      logic [12:0]        out_w;
      logic [12:0]        out_h;
      logic [8:0]         weight;
      logic signed [12:0] off_x;
      logic signed [12:0] off_y;
   } rgbq_cfg_type;

   // One queued unit of work: a store write or a fully addressed quad.
   typedef struct packed {
      logic                           is_load;
      logic [STORE_AW-1:0]            load_addr;
      logic [PIX_W-1:0]               load_pixel;
      logic [3:0][STORE_AW-1:0]       addr;
      logic [3:0][PIX_W-1:0]          comp;
      logic [10:0]                    qc;
      logic [10:0]                    qr;
   } rgbq_entry_type;

endpackage

// File: rtl/rgbq_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module rgbq_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// File: rtl/rgbq_div.sv
// Restoring divider, one quotient bit per step, for the scaled coordinates.
// Depends on rgbq_pkg.
module rgbq_div (
   input  logic                            clock,
   input  logic                            load,
   input  logic                            step,
   input  logic [rgbq_pkg::DIVIDEND_W-1:0] dividend,
   input  logic [rgbq_pkg::DIVISOR_W-1:0]  divisor,
   output logic [rgbq_pkg::QUOT_W-1:0]     quotient
);
   import rgbq_pkg::*;

   logic [DIVIDEND_W-1:0] rem_ff, rem_in, dsh_ff, dsh_in;
   logic [QUOT_W-1:0]     q_ff, q_in;

   // The dividend is below divisor * 2^QUOT_W, so the quotient fits.
   always_comb begin
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      q_in   = q_ff;
      if (load) begin
         rem_in = dividend;
         dsh_in = {divisor, {(DIVIDEND_W-DIVISOR_W){1'b0}}};
         q_in   = '0;
      end else if (step) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            q_in   = {q_ff[QUOT_W-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[QUOT_W-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
   end

   assign quotient = q_ff;
endmodule

// File: rtl/rgbq_queue.sv
// Two-entry queue between the front and back parts.
// Depends on rgbq_pkg.
module rgbq_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  rgbq_pkg::rgbq_entry_type push_data,
   input  logic                     pop,
   output rgbq_pkg::rgbq_entry_type head,
   output logic                     full,
   output logic                     empty
);
   import rgbq_pkg::*;

   rgbq_entry_type slot_ff [2];
   logic           wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head  = slot_ff[rd_ptr_ff];
   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
endmodule

// File: rtl/rgbq_front.sv
// Front part: accepts items, drops quads outside the frame, scales the quad
// coordinates through four dividers and queues store addresses.
// Depends on rgbq_pkg, rgbq_div.
module rgbq_front (
   input  logic                     clock,
   input  logic                     reset,
   input  rgbq_pkg::rgbq_cfg_type   cfg,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_opcode,
   input  logic [19:0]              req_visible_index,
   input  logic [23:0]              req_visible_pixel,
   input  logic [10:0]              req_quad_col,
   input  logic [10:0]              req_quad_row,
   input  logic [23:0]              req_comp_top_left,
   input  logic [23:0]              req_comp_top_right,
   input  logic [23:0]              req_comp_bottom_left,
   input  logic [23:0]              req_comp_bottom_right,
   input  logic                     q_full,
   output logic                     q_push,
   output rgbq_pkg::rgbq_entry_type q_data
);
   import rgbq_pkg::*;

   typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_type;

   front_state_type       state_ff, state_in;
   logic [3:0]            step_ff, step_in;
   logic [3:0][PIX_W-1:0] comp_ff;
   logic [10:0]           qc_ff, qr_ff;
   logic                  accept, in_frame, div_load, div_step;
   logic [11:0]           x0, y0, x1, y1;
   logic [DIVIDEND_W-1:0] dvd [4];
   logic [QUOT_W-1:0]     quot [4];
   logic [9:0]            vx [2];
   logic [9:0]            vy [2];
   logic [13:0]           sum_c;
   logic [20:0]           lin;
   rgbq_entry_type        fuse_entry, load_entry;

   assign x0 = {req_quad_col, 1'b0};
   assign y0 = {req_quad_row, 1'b0};
   assign x1 = x0 + 12'd1;
   assign y1 = y0 + 12'd1;
   assign in_frame = ({1'b0, x0} < cfg.out_w) && ({1'b0, y0} < cfg.out_h);

   assign req_stall = !((state_ff == F_IDLE) && !q_full);
   assign accept    = req_valid && !req_stall;
   assign div_load  = accept && (req_opcode == OP_FUSE) && in_frame;
   assign div_step  = (state_ff == F_DIV);

   assign dvd[0] = DIVIDEND_W'(x0) * DIVIDEND_W'(cfg.vis_w);
   assign dvd[1] = DIVIDEND_W'(x1) * DIVIDEND_W'(cfg.vis_w);
   assign dvd[2] = DIVIDEND_W'(y0) * DIVIDEND_W'(cfg.vis_h);
   assign dvd[3] = DIVIDEND_W'(y1) * DIVIDEND_W'(cfg.vis_h);

   for (genvar g = 0; g < 4; g++) begin : g_div
      rgbq_div u_div (
         .clock    (clock),
         .load     (div_load),
         .step     (div_step),
         .dividend (dvd[g]),
         .divisor  ((g < 2) ? cfg.out_w : cfg.out_h),
         .quotient (quot[g])
      );
   end

   // Offset and clamp of the scaled columns and rows.
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         sum_c = 14'({3'b0, quot[k]}) + 14'(cfg.off_x);
         if (sum_c[13]) begin
            vx[k] = '0;
         end else if (sum_c[12:0] > 13'(cfg.vis_w - 11'd1)) begin
            vx[k] = 10'(cfg.vis_w - 11'd1);
         end else begin
            vx[k] = sum_c[9:0];
         end
         sum_c = 14'({3'b0, quot[k+2]}) + 14'(cfg.off_y);
         if (sum_c[13]) begin
            vy[k] = '0;
         end else if (sum_c[12:0] > 13'(cfg.vis_h - 11'd1)) begin
            vy[k] = 10'(cfg.vis_h - 11'd1);
         end else begin
            vy[k] = sum_c[9:0];
         end
      end
   end

   always_comb begin
      fuse_entry            = '0;
      fuse_entry.is_load    = 1'b0;
      fuse_entry.comp       = comp_ff;
      fuse_entry.qc         = qc_ff;
      fuse_entry.qr         = qr_ff;
      for (int p = 0; p < 4; p++) begin
         lin = 21'(vy[p >> 1]) * 21'(cfg.vis_w) + 21'(vx[p & 1]);
         fuse_entry.addr[p] = lin[STORE_AW-1:0];
      end
      load_entry            = '0;
      load_entry.is_load    = 1'b1;
      load_entry.load_addr  = req_visible_index;
      load_entry.load_pixel = req_visible_pixel;
   end

   always_comb begin
      q_push = 1'b0;
      q_data = load_entry;
      if (accept && (req_opcode == OP_LOAD)) begin
         q_push = 1'b1;
      end else if ((state_ff == F_PUSH) && !q_full) begin
         q_push = 1'b1;
         q_data = fuse_entry;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         F_IDLE: begin
            step_in = '0;
            if (div_load) begin
               state_in = F_DIV;
            end
         end
         F_DIV: begin
            step_in = step_ff + 4'd1;
            if (step_ff == 4'(QUOT_W - 1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
      if (div_load) begin
         comp_ff <= {req_comp_bottom_right, req_comp_bottom_left,
                     req_comp_top_right, req_comp_top_left};
         qc_ff   <= req_quad_col;
         qr_ff   <= req_quad_row;
      end
   end
endmodule

// File: rtl/rgbq_back.sv
// Back part: writes loads into the store, reads four samples per quad,
// blends, converts to Y/Cb/Cr and holds the result in the output register.
// Depends on rgbq_pkg, rgbq_ram.
module rgbq_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [8:0]               weight,
   input  rgbq_pkg::rgbq_entry_type head,
   input  logic                     q_empty,
   output logic                     q_pop,
   output logic                     ram_we,
   output logic                     ram_re,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_luma_top_left,
   output logic [7:0]               rsp_luma_top_right,
   output logic [7:0]               rsp_luma_bottom_left,
   output logic [7:0]               rsp_luma_bottom_right,
   output logic [7:0]               rsp_chroma_blue,
   output logic [7:0]               rsp_chroma_red,
   output logic [10:0]              rsp_out_quad_col,
   output logic [10:0]              rsp_out_quad_row
);
   import rgbq_pkg::*;

   typedef enum logic [1:0] {B_IDLE, B_RUN, B_DONE} back_state_type;

   back_state_type      state_ff, state_in;
   logic [2:0]          cnt_ff, cnt_in;
   rgbq_entry_type      ent_ff;
   logic [PIX_W-1:0]    rdata, rgb_ff, rgb_in;
   logic [STORE_AW-1:0] ram_addr;
   logic [PIX_W-1:0]    ram_wdata;
   logic [2:0]          bl_idx3, cv_idx3;
   logic [1:0]          bl_idx, cv_idx;
   logic                do_blend, do_conv, out_free, take;
   logic [8:0]          w_inv;
   logic [3:0][7:0]     luma_ff;
   logic [9:0]          cb_sum_ff, cb_sum_in, cr_sum_ff, cr_sum_in;
   logic [15:0]         y_acc;
   logic [16:0]         cb_acc, cr_acc;
   logic [7:0]          luma_new;
   logic [7:0]          vc, cc, rr, gg, bb;
   logic [16:0]         mix;
   logic                rsp_valid_ff;
   logic [3:0][7:0]     o_luma_ff;
   logic [7:0]          o_cb_ff, o_cr_ff;
   logic [10:0]         o_qc_ff, o_qr_ff;

   assign q_pop    = (state_ff == B_IDLE) && !q_empty;
   assign take     = q_pop && !head.is_load;
   assign ram_we   = q_pop && head.is_load;
   assign ram_re   = (state_ff == B_RUN) && (cnt_ff < 3'd4);
   assign ram_addr = ram_we ? head.load_addr : ent_ff.addr[cnt_ff[1:0]];
   assign ram_wdata = head.load_pixel;

   rgbq_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_store (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (rdata)
   );

   // Read data of sample k arrives at count k+1, its conversion at k+2.
   assign bl_idx3  = cnt_ff - 3'd1;
   assign cv_idx3  = cnt_ff - 3'd2;
   assign bl_idx   = bl_idx3[1:0];
   assign cv_idx   = cv_idx3[1:0];
   assign do_blend = (state_ff == B_RUN) && (cnt_ff >= 3'd1) && (cnt_ff <= 3'd4);
   assign do_conv  = (state_ff == B_RUN) && (cnt_ff >= 3'd2);
   assign w_inv    = 9'd256 - weight;

   always_comb begin
      rgb_in = rgb_ff;
      for (int c = 0; c < 3; c++) begin
         vc  = rdata[8*c +: 8];
         cc  = ent_ff.comp[bl_idx][8*c +: 8];
         mix = 17'(vc) * 17'(weight) + 17'(cc) * 17'(w_inv);
         if (do_blend) begin
            rgb_in[8*c +: 8] = mix[15:8];
         end
      end
   end

   always_comb begin
      rr = rgb_ff[23:16];
      gg = rgb_ff[15:8];
      bb = rgb_ff[7:0];
      y_acc  = 16'(66 * rr) + 16'(129 * gg) + 16'(25 * bb) + 16'd128;
      // Biased by 128*256, plus 128 for rounding, so both stay non-negative before the shift.
      cb_acc = 17'(112 * bb) + 17'd32896 - 17'(38 * rr) - 17'(74 * gg);
      cr_acc = 17'(112 * rr) + 17'd32896 - 17'(94 * gg) - 17'(18 * bb);
      luma_new  = y_acc[15:8] + 8'd16;
      cb_sum_in = cb_sum_ff;
      cr_sum_in = cr_sum_ff;
      if (take) begin
         cb_sum_in = '0;
         cr_sum_in = '0;
      end else if (do_conv) begin
         cb_sum_in = cb_sum_ff + 10'(cb_acc[15:8]);
         cr_sum_in = cr_sum_ff + 10'(cr_acc[15:8]);
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         B_IDLE: begin
            cnt_in = '0;
            if (take) begin
               state_in = B_RUN;
            end
         end
         B_RUN: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd5) begin
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (out_free) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if ((state_ff == B_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (take) begin
         ent_ff <= head;
      end
      rgb_ff    <= rgb_in;
      cb_sum_ff <= cb_sum_in;
      cr_sum_ff <= cr_sum_in;
      if (do_conv) begin
         luma_ff[cv_idx] <= luma_new;
      end
      if ((state_ff == B_DONE) && out_free) begin
         o_luma_ff <= luma_ff;
         o_cb_ff   <= cb_sum_ff[9:2];
         o_cr_ff   <= cr_sum_ff[9:2];
         o_qc_ff   <= ent_ff.qc;
         o_qr_ff   <= ent_ff.qr;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_luma_top_left     = o_luma_ff[0];
   assign rsp_luma_top_right    = o_luma_ff[1];
   assign rsp_luma_bottom_left  = o_luma_ff[2];
   assign rsp_luma_bottom_right = o_luma_ff[3];
   assign rsp_chroma_blue       = o_cb_ff;
   assign rsp_chroma_red        = o_cr_ff;
   assign rsp_out_quad_col      = o_qc_ff;
   assign rsp_out_quad_row      = o_qr_ff;
endmodule

// File: rtl/blend_rgb_to_nv12_quad_top.sv
// Top level of the visible-over-composite blend with BT.601 NV12 quad output.
// Depends on rgbq_pkg, rgbq_front, rgbq_queue, rgbq_back.
//
//   Channel  Direction  Handshake          Carries
//   req_     in         valid / stall      a store load or a 2x2 quad request
//   rsp_     out        valid / stall      four Y bytes, Cb, Cr, quad position
//   csr_     in         valid / ready      register index and write data
//
// A load item passes through the front without waiting and takes one store write in the back.
// A quad item is held in the front while the four restoring dividers scale its
// coordinates (one quotient bit per cycle, 11 bits), and in the back it takes four
// single-port store reads, then blend and conversion, plus any output stall. The
// front takes no new item until the current quad has been pushed to the queue.
// Reset is synchronous and active high; the store itself is not cleared.
// The front and back stall independently through a two-item queue; the result
// register lets the back start on the next item while a result waits.
module blend_rgb_to_nv12_quad_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [19:0] req_visible_index,
   input  logic [23:0] req_visible_pixel,
   input  logic [10:0] req_quad_col,
   input  logic [10:0] req_quad_row,
   input  logic [23:0] req_comp_top_left,
   input  logic [23:0] req_comp_top_right,
   input  logic [23:0] req_comp_bottom_left,
   input  logic [23:0] req_comp_bottom_right,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_luma_top_left,
   output logic [7:0]  rsp_luma_top_right,
   output logic [7:0]  rsp_luma_bottom_left,
   output logic [7:0]  rsp_luma_bottom_right,
   output logic [7:0]  rsp_chroma_blue,
   output logic [7:0]  rsp_chroma_red,
   output logic [10:0] rsp_out_quad_col,
   output logic [10:0] rsp_out_quad_row,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [12:0] csr_wdata
);
   import rgbq_pkg::*;

   // Raw register values before saturation; narrower registers keep the low bits written.
   logic [10:0]        vis_w_ff, vis_h_ff;
   logic [12:0]        out_w_ff, out_h_ff;
   logic [8:0]         weight_ff;
   logic [12:0]        off_x_ff, off_y_ff;
   rgbq_cfg_type       cfg;
   rgbq_entry_type     q_in_data, q_head;
   logic               q_push, q_pop, q_full, q_empty, ram_we, ram_re;
   logic               csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vis_w_ff  <= 11'(VIS_MAX_W);
         vis_h_ff  <= 11'(VIS_MAX_H);
         out_w_ff  <= 13'd1920;
         out_h_ff  <= 13'd1080;
         weight_ff <= 9'd128;
         off_x_ff  <= '0;
         off_y_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VIS_W:  vis_w_ff  <= csr_wdata[10:0];
            CSR_VIS_H:  vis_h_ff  <= csr_wdata[10:0];
            CSR_OUT_W:  out_w_ff  <= csr_wdata;
            CSR_OUT_H:  out_h_ff  <= csr_wdata;
            CSR_WEIGHT: weight_ff <= csr_wdata[8:0];
            CSR_OFF_X:  off_x_ff  <= csr_wdata;
            CSR_OFF_Y:  off_y_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Saturate the sizes and weight into their legal ranges; output sizes are
   // also forced even so that every quad is full.
   always_comb begin
      cfg.vis_w = (vis_w_ff == '0) ? 11'd1 :
                  (vis_w_ff > 11'(VIS_MAX_W)) ? 11'(VIS_MAX_W) : vis_w_ff;
      cfg.vis_h = (vis_h_ff == '0) ? 11'd1 :
                  (vis_h_ff > 11'(VIS_MAX_H)) ? 11'(VIS_MAX_H) : vis_h_ff;
      cfg.out_w = (out_w_ff < 13'd2) ? 13'd2 :
                  (out_w_ff > 13'(OUT_MAX_W)) ? 13'(OUT_MAX_W) : out_w_ff;
      cfg.out_h = (out_h_ff < 13'd2) ? 13'd2 :
                  (out_h_ff > 13'(OUT_MAX_H)) ? 13'(OUT_MAX_H) : out_h_ff;
      cfg.out_w[0] = 1'b0;
      cfg.out_h[0] = 1'b0;
      cfg.weight = (weight_ff > 9'd256) ? 9'd256 : weight_ff;
      cfg.off_x  = off_x_ff;
      cfg.off_y  = off_y_ff;
   end

   rgbq_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_opcode            (req_opcode),
      .req_visible_index     (req_visible_index),
      .req_visible_pixel     (req_visible_pixel),
      .req_quad_col          (req_quad_col),
      .req_quad_row          (req_quad_row),
      .req_comp_top_left     (req_comp_top_left),
      .req_comp_top_right    (req_comp_top_right),
      .req_comp_bottom_left  (req_comp_bottom_left),
      .req_comp_bottom_right (req_comp_bottom_right),
      .q_full                (q_full),
      .q_push                (q_push),
      .q_data                (q_in_data)
   );

   rgbq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   rgbq_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .weight                (cfg.weight),
      .head                  (q_head),
      .q_empty               (q_empty),
      .q_pop                 (q_pop),
      .ram_we                (ram_we),
      .ram_re                (ram_re),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_luma_top_left     (rsp_luma_top_left),
      .rsp_luma_top_right    (rsp_luma_top_right),
      .rsp_luma_bottom_left  (rsp_luma_bottom_left),
      .rsp_luma_bottom_right (rsp_luma_bottom_right),
      .rsp_chroma_blue       (rsp_chroma_blue),
      .rsp_chroma_red        (rsp_chroma_red),
      .rsp_out_quad_col      (rsp_out_quad_col),
      .rsp_out_quad_row      (rsp_out_quad_row)
   );

   // The queue is never pushed while full.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("queue push while full");

   // The single store port never writes and reads in the same cycle.
   a_port_excl: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re)) else $error("store write and read collide");

   // Limited-range luma of the top-left and bottom-right samples stays within 16..235.
   a_luma_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_luma_top_left >= 8'd16) && (rsp_luma_top_left <= 8'd235)
                 && (rsp_luma_bottom_right >= 8'd16)
                 && (rsp_luma_bottom_right <= 8'd235))
      else $error("luma outside limited range");

   // No result is offered right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result valid after reset");
endmodule

// File: dv/blend_rgb_to_nv12_quad_top_tb.sv
// Self-checking testbench for blend_rgb_to_nv12_quad_top: store loads, quad
// fuses and CSR writes.
// Depends on rgbq_pkg and the block's RTL; the prediction is computed here.
`timescale 1ns / 100ps

module blend_rgb_to_nv12_quad_top_tb;
   import rgbq_pkg::*;

   // One request item as it is presented on the req_ channel.
   typedef struct packed {
      logic               opcode;
      logic [19:0]        index;
      logic [23:0]        pixel;
      logic [10:0]        qc;
      logic [10:0]        qr;
      logic [3:0][23:0]   comp;
   } quad_req_type;

   // One result item: four luma bytes, averaged chroma and the echoed position.
   typedef struct packed {
      logic [3:0][7:0] luma;
      logic [7:0]      cb;
      logic [7:0]      cr;
      logic [10:0]     qc;
      logic [10:0]     qr;
   } nv12_quad_type;

   // Scoreboard: keeps its own copy of the registers and the visible store,
   // predicts each quad when its request is accepted and checks results in order.
   class nv12_scoreboard;
      logic [10:0]        vis_w, vis_h;
      logic [12:0]        out_w, out_h;
      logic [8:0]         weight;
      logic signed [12:0] off_x, off_y;
      logic [23:0]        vis_mem [int];
      nv12_quad_type      pending [$];
      int                 errors;

      function new();
         vis_w = 1024; vis_h = 1024; out_w = 1920; out_h = 1080;
         weight = 128; off_x = 0; off_y = 0; errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [12:0] data);
         case (idx)
            CSR_VIS_W:  vis_w = data[10:0];
            CSR_VIS_H:  vis_h = data[10:0];
            CSR_OUT_W:  out_w = data;
            CSR_OUT_H:  out_h = data;
            CSR_WEIGHT: weight = data[8:0];
            CSR_OFF_X:  off_x = data;
            CSR_OFF_Y:  off_y = data;
            default: ;
         endcase
      endfunction

      // Effective sizes after saturation; output sizes are rounded down to even.
      function void frame_sizes(output int vw, output int vh,
                                output int ow, output int oh);
         vw = (vis_w == 0) ? 1 : (vis_w > VIS_MAX_W ? VIS_MAX_W : vis_w);
         vh = (vis_h == 0) ? 1 : (vis_h > VIS_MAX_H ? VIS_MAX_H : vis_h);
         ow = (out_w < 2) ? 2 : (out_w > OUT_MAX_W ? OUT_MAX_W : out_w);
         oh = (out_h < 2) ? 2 : (out_h > OUT_MAX_H ? OUT_MAX_H : out_h);
         ow = ow & ~1;
         oh = oh & ~1;
      endfunction

      // Store address of the visible pixel sampled for output pixel (x, y).
      function int sample_addr(int x, int y);
         int vw, vh, ow, oh;
         longint vx, vy;
         frame_sizes(vw, vh, ow, oh);
         vx = (longint'(x) * vw) / ow + off_x;
         vy = (longint'(y) * vh) / oh + off_y;
         if (vx < 0) vx = 0;
         if (vx > vw - 1) vx = vw - 1;
         if (vy < 0) vy = 0;
         if (vy > vh - 1) vy = vh - 1;
         return int'((vy * vw + vx) & 64'hFFFFF);
      endfunction

      function void note_request(quad_req_type r);
         int vw, vh, ow, oh, w, cb_sum, cr_sum, ch, x0, y0;
         int rgb [3];
         logic [23:0] vis;
         nv12_quad_type q;
         if (r.opcode == OP_LOAD) begin
            vis_mem[int'(r.index)] = r.pixel;
            return;
         end
         frame_sizes(vw, vh, ow, oh);
         x0 = 2 * r.qc;
         y0 = 2 * r.qr;
         if (x0 >= ow || y0 >= oh) return;
         w = (weight > 256) ? 256 : weight;
         cb_sum = 0;
         cr_sum = 0;
         for (int i = 0; i < 4; i++) begin
            vis = vis_mem[sample_addr(x0 + (i & 1), y0 + (i >> 1))];
            for (int c = 0; c < 3; c++) begin
               ch = 16 - 8 * c;
               rgb[c] = (int'((vis >> ch) & 8'hFF) * w
                         + int'((r.comp[i] >> ch) & 8'hFF) * (256 - w)) >> 8;
            end
            q.luma[i] = 8'(((66 * rgb[0] + 129 * rgb[1] + 25 * rgb[2] + 128) >> 8) + 16);
            // The added 128*256 keeps the floor shift on non-negative values.
            cb_sum += (-38 * rgb[0] - 74 * rgb[1] + 112 * rgb[2] + 128 + 32768) >> 8;
            cr_sum += (112 * rgb[0] - 94 * rgb[1] - 18 * rgb[2] + 128 + 32768) >> 8;
         end
         cb_sum = cb_sum >> 2;
         cr_sum = cr_sum >> 2;
         q.cb = (cb_sum > 255) ? 8'd255 : 8'(cb_sum);
         q.cr = (cr_sum > 255) ? 8'd255 : 8'(cr_sum);
         q.qc = r.qc;
         q.qr = r.qr;
         pending.push_back(q);
      endfunction

      function void check_result(nv12_quad_type got);
         nv12_quad_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: unexpected quad at (%0d,%0d)", $realtime, got.qc, got.qr);
            return;
         end
         want = pending.pop_front();
         if (got.luma !== want.luma || got.cb !== want.cb || got.cr !== want.cr ||
             got.qc !== want.qc || got.qr !== want.qr) begin
            errors++;
            if (errors <= 10)
               $display({"%0t: quad mismatch exp Y=%h Cb=%h Cr=%h pos=(%0d,%0d)",
                         " act Y=%h Cb=%h Cr=%h pos=(%0d,%0d)"},
                        $realtime, want.luma, want.cb, want.cr, want.qc, want.qr,
                        got.luma, got.cb, got.cr, got.qc, got.qr);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_opcode = OP_LOAD;
   logic [19:0] req_visible_index = '0;
   logic [23:0] req_visible_pixel = '0;
   logic [10:0] req_quad_col = '0;
   logic [10:0] req_quad_row = '0;
   logic [23:0] req_comp_top_left = '0;
   logic [23:0] req_comp_top_right = '0;
   logic [23:0] req_comp_bottom_left = '0;
   logic [23:0] req_comp_bottom_right = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_luma_top_left, rsp_luma_top_right;
   logic [7:0]  rsp_luma_bottom_left, rsp_luma_bottom_right;
   logic [7:0]  rsp_chroma_blue, rsp_chroma_red;
   logic [10:0] rsp_out_quad_col, rsp_out_quad_row;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = CSR_VIS_W;
   logic [12:0] csr_wdata = '0;

   // Percent of cycles in which the sender idles and the receiver stalls.
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   nv12_scoreboard sb = new();

   blend_rgb_to_nv12_quad_top DUT (.*);

   // 12 ns clock period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The receiver stalls at random; with a zero percentage it never stalls.
   always @(posedge clock) begin
      rsp_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
   end

   // Every result accepted at an edge goes to the scoreboard. Values are read
   // at the edge, before any update of that edge lands.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result({rsp_luma_bottom_right, rsp_luma_bottom_left, rsp_luma_top_right,
                          rsp_luma_top_left, rsp_chroma_blue, rsp_chroma_red,
                          rsp_out_quad_col, rsp_out_quad_row});
      end
   end

   // Presents one request item and returns at the edge where it is accepted.
   // Valid stays high afterward; it is lowered when the next call idles, or by a CSR write or a drain.
   task automatic push_req(quad_req_type r);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_opcode            <= r.opcode;
      req_visible_index     <= r.index;
      req_visible_pixel     <= r.pixel;
      req_quad_col          <= r.qc;
      req_quad_row          <= r.qr;
      req_comp_top_left     <= r.comp[0];
      req_comp_top_right    <= r.comp[1];
      req_comp_bottom_left  <= r.comp[2];
      req_comp_bottom_right <= r.comp[3];
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
   endtask

   task automatic load_pixel(int addr, logic [23:0] pix);
      quad_req_type r;
      r = '0;
      r.opcode = OP_LOAD;
      r.index = 20'(addr);
      r.pixel = pix;
      r.qc = 11'($urandom);
      r.qr = 11'($urandom);
      r.comp = {$urandom, $urandom, $urandom};
      push_req(r);
   endtask

   // Sends a quad, loading first any store entry that it would read and that
   // was never written. Quads outside the frame read nothing.
   task automatic fuse_quad(int qc, int qr, logic [3:0][23:0] comp);
      quad_req_type r;
      int vw, vh, ow, oh, addr;
      sb.frame_sizes(vw, vh, ow, oh);
      if (2 * qc < ow && 2 * qr < oh) begin
         for (int i = 0; i < 4; i++) begin
            addr = sb.sample_addr(2 * qc + (i & 1), 2 * qr + (i >> 1));
            if (!sb.vis_mem.exists(addr)) load_pixel(addr, 24'($urandom));
         end
      end
      r.opcode = OP_FUSE;
      r.index = 20'($urandom);
      r.pixel = 24'($urandom);
      r.qc = 11'(qc);
      r.qr = 11'(qr);
      r.comp = comp;
      push_req(r);
   endtask

   task automatic write_csr(logic [2:0] idx, int data);
      req_valid <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 13'(data);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.write_reg(idx, 13'(data));
   endtask

   // Lets the block drain. Loads and out-of-frame quads give no result, so a
   // margin past the front and back latency follows the last expected quad.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_frame(int vw, int vh, int ow, int oh, int w, int ox, int oy);
      drain();
      write_csr(CSR_VIS_W, vw);
      write_csr(CSR_VIS_H, vh);
      write_csr(CSR_OUT_W, ow);
      write_csr(CSR_OUT_H, oh);
      write_csr(CSR_WEIGHT, w);
      write_csr(CSR_OFF_X, ox);
      write_csr(CSR_OFF_Y, oy);
   endtask

   // Mostly in-frame quads with random content; some random loads anywhere in
   // the store and some quads that may fall outside the frame.
   task automatic random_items(int count);
      int vw, vh, ow, oh, pick;
      sb.frame_sizes(vw, vh, ow, oh);
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 15)
            load_pixel($urandom_range(20'hFFFFF), 24'($urandom));
         else if (pick < 25)
            fuse_quad($urandom_range(2047), $urandom_range(2047),
                      {$urandom, $urandom, $urandom});
         else
            fuse_quad($urandom_range(ow / 2 - 1), $urandom_range(oh / 2 - 1),
                      {$urandom, $urandom, $urandom});
      end
   endtask

   task automatic set_pressure(int phase);
      case (phase % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
         default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
   endtask

   initial begin
      logic [23:0] shades [8];
      shades = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
                 24'h0000FF, 24'h808080, 24'h00FFFF, 24'hFF00FF};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: a 4x4 visible frame upscaled to 8x8, with the color
      // extremes in the store and on the composite side.
      set_frame(4, 4, 8, 8, 128, 0, 0);
      for (int a = 0; a < 16; a++) load_pixel(a, shades[a % 8]);
      fuse_quad(0, 0, {4{24'h000000}});
      fuse_quad(3, 3, {4{24'hFFFFFF}});
      fuse_quad(1, 2, {24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF});
      fuse_quad(2, 1, {24'h00FFFF, 24'hFF00FF, 24'hFFFF00, 24'h000000});
      // Quads just past the right edge, the bottom edge and the far corner.
      fuse_quad(4, 0, {4{24'h123456}});
      fuse_quad(0, 4, {4{24'h654321}});
      fuse_quad(2047, 2047, {4{24'hFFFFFF}});
      // A load at the top address and a fuse whose ignored fields are all ones.
      load_pixel(20'hFFFFF, 24'hFFFFFF);
      begin
         quad_req_type r;
         r.opcode = OP_FUSE;
         r.index = 20'hFFFFF;
         r.pixel = 24'hFFFFFF;
         r.qc = 11'd1;
         r.qr = 11'd1;
         r.comp = {4{24'h7F7F7F}};
         push_req(r);
      end

      // Register extremes, out-of-range values that saturate, odd output
      // sizes, weights beyond 256 and offsets at both signed limits.
      for (int ph = 0; ph < 11; ph++) begin
         set_pressure(ph);
         case (ph)
            0: set_frame(1, 1, 2, 2, 0, 0, 0);
            1: set_frame(1024, 1, 2, 4096, 256, 0, 0);
            2: set_frame(2047, 2047, 8191, 8191, 511, -4096, 4095);
            3: set_frame(0, 0, 0, 1, 256, 2048, -2048);
            4: set_frame(7, 5, 13, 11, 37, -2, 3);
            5: set_frame(16, 16, 6, 6, 200, 1, -1);
            6: set_frame(1024, 1024, 4096, 4096, 255, 0, 0);
            default: set_frame($urandom_range(1, 40), $urandom_range(1, 40),
                               2 * $urandom_range(1, 40), 2 * $urandom_range(1, 40),
                               $urandom_range(256), $signed($urandom_range(16)) - 8,
                               $signed($urandom_range(16)) - 8);
         endcase
         random_items(ph == 6 ? 60 : 125);
      end

      drain();
      if (sb.errors == 0)
         $display("blend_rgb_to_nv12_quad_top_tb OK");
      else
         $display("blend_rgb_to_nv12_quad_top_tb NOT OK");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("blend_rgb_to_nv12_quad_top_tb NOT OK");
      $finish;
   end

endmodule

// File: blend_rgb_to_nv12_quad_top.f
rtl/rgbq_pkg.sv
rtl/rgbq_ram.sv
rtl/rgbq_div.sv
rtl/rgbq_queue.sv
rtl/rgbq_front.sv
rtl/rgbq_back.sv
rtl/blend_rgb_to_nv12_quad_top.sv
dv/blend_rgb_to_nv12_quad_top_tb.sv
